// ===== src/signed_binary_to_decimal_ascii_assert.svh =====
// Assertion macros for the decimal text converter.
// The clock and reset are taken from the including module (clk, rst_n).
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SBDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbda assertion failed");

// Next-cycle implication.
`define SBDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbda assertion failed");

`else

`define SBDA_ASSERT_NOW(label, ante, cons)
`define SBDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/sbda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;  // 2^32 - 1 has ten decimal digits
  localparam int CNT_W      = 5;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;  // '-'
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIG
  } state_t;

  // Per-cycle command to the row of digit cells
  typedef struct packed {
    logic clr;    // zero the digit
    logic conv;   // add-3 and shift one binary bit in
    logic shift;  // move digits one place toward the top
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/sbda_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbda_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== src/sbda_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ===== src/sbda_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One BCD digit of the double-dabble row
module sbda_cell (
  input  logic                          clk,
  input  sbda_pkg::cell_ctrl_t          ctrl,
  input  logic                          bit_in,
  input  logic [sbda_pkg::DIGIT_W-1:0]  digit_in,
  output logic                          bit_out,
  output logic [sbda_pkg::DIGIT_W-1:0]  digit_out
);
  import sbda_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  assign adj = (digit_r >= ADJ_LIMIT) ? (digit_r + ADJ_ADD) : digit_r;

  // carry toward the next more significant digit
  assign bit_out   = adj[DIGIT_W-1];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// ===== src/signed_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                      | Handshake
// ---------+-----+------------------------------+-------------------
// in_ch    | in  | value (signed 32)            | valid/ready
// out_ch   | out | char_code (8), last (1)      | valid/ready
//
// A word is loaded, run through double dabble in the ten-cell BCD row, given
// a '-' on negatives and then shifted out of the row one digit at a time
// (leading zeros are skipped in place).
// rst_n is synchronous, active low; it clears the controller and output valid.
// A stalled output holds the row (skipped leading zeros still shift); the last
// character may wait in the output register while the next word is accepted.
module signed_binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  sbda_in_if.sink     in_ch,
  sbda_out_if.source  out_ch
);
  import sbda_pkg::*;
  `include "signed_binary_to_decimal_ascii_assert.svh"

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
  localparam logic [CNT_W-1:0] DIG_LOAD  = CNT_W'(NUM_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctrl_t         cell_ctrl;
  logic               in_acc;
  logic               slot_free;
  logic               zero_lead;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit_last;
  logic [VALUE_W-1:0] raw;

  logic               carry [NUM_DIGITS];
  logic [DIGIT_W-1:0] dig_q [NUM_DIGITS];
  logic [DIGIT_W-1:0] dig_lo [NUM_DIGITS];
  logic               carry_top;
  logic [DIGIT_W-1:0] top_dig;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign raw         = in_ch.value;
  assign top_dig     = dig_q[NUM_DIGITS-1];
  assign zero_lead   = !started_r && (top_dig == '0) && (cnt_r != CNT_ONE);

  // Row of digit cells; cell 0 is the least significant digit
  assign carry[0] = mag_r[VALUE_W-1];
  assign dig_lo[0] = '0;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign dig_lo[i] = dig_q[i-1];
    end
    if (i < NUM_DIGITS - 1) begin : g_mid
      sbda_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .bit_in    (carry[i]),
        .digit_in  (dig_lo[i]),
        .bit_out   (carry[i+1]),
        .digit_out (dig_q[i])
      );
    end else begin : g_top
      sbda_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .bit_in    (carry[i]),
        .digit_in  (dig_lo[i]),
        .bit_out   (carry_top),
        .digit_out (dig_q[i])
      );
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_r == CONV_LAST) state_nxt = neg_r ? ST_SIGN : ST_DIG;
      end
      ST_SIGN: begin
        if (slot_free) state_nxt = ST_DIG;
      end
      ST_DIG: begin
        if (emit && emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    cell_ctrl = '0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cell_ctrl.clr = in_acc;
      end
      ST_CONV: begin
        cell_ctrl.conv = 1'b1;
      end
      ST_SIGN: begin
        emit      = slot_free;
        emit_char = CHAR_MINUS;
      end
      ST_DIG: begin
        if (zero_lead) begin
          cell_ctrl.shift = 1'b1;
        end else if (slot_free) begin
          emit            = 1'b1;
          emit_char       = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_dig};
          emit_last       = (cnt_r == CNT_ONE);
          cell_ctrl.shift = 1'b1;
        end
      end
      default: begin
        cell_ctrl = '0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_acc) begin
      neg_nxt     = raw[VALUE_W-1];
      mag_nxt     = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      cnt_nxt     = '0;
      started_nxt = 1'b0;
    end else if (state_r == ST_CONV) begin
      mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = (cnt_r == CONV_LAST) ? DIG_LOAD : (cnt_r + CNT_ONE);
    end else if (cell_ctrl.shift) begin
      cnt_nxt = cnt_r - CNT_ONE;
      if (emit) started_nxt = 1'b1;
    end

    // output register
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  // Checks
  `SBDA_ASSERT_NOW(a_no_top_carry, state_r == ST_CONV, !carry_top)
  `SBDA_ASSERT_NOW(a_top_is_decimal, state_r == ST_DIG, top_dig <= 4'd9)
  `SBDA_ASSERT_NEXT(a_last_ends_word, emit && emit_last, state_r == ST_IDLE)
  `SBDA_ASSERT_NEXT(a_conv_len, (state_r == ST_CONV) && (cnt_r == CONV_LAST), state_r == ST_SIGN || state_r == ST_DIG)
  `SBDA_ASSERT_NOW(a_char_legal, out_valid_r, out_char_r == CHAR_MINUS || (out_char_r >= CHAR_ZERO && out_char_r <= 8'd57))

endmodule

`default_nettype wire
